// File: design/pdtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdtc_pkg;

  // Transaction opcodes on the item channel
  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TICK    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Domain power states
  typedef enum logic [1:0] {
    PS_OFF = 2'd0,
    PS_ON  = 2'd1,
    PS_CG  = 2'd2
  } pstate_t;

  // Requested state codes
  localparam logic [1:0] CODE_OFF_A = 2'd0;
  localparam logic [1:0] CODE_CG    = 2'd1;
  localparam logic [1:0] CODE_OFF_B = 2'd2;
  localparam logic [1:0] CODE_ON    = 2'd3;

  // Delay slots within one domain's table
  localparam logic [1:0] SLOT_ON_OFF = 2'd0;
  localparam logic [1:0] SLOT_OFF_ON = 2'd1;
  localparam logic [1:0] SLOT_ON_CG  = 2'd2;
  localparam logic [1:0] SLOT_CG_ON  = 2'd3;

  localparam int unsigned DOMAIN_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned REPORTED_DOMAINS = 4;

  // One accepted transaction as seen by every domain
  typedef struct packed {
    op_t                 op;
    logic [DOMAIN_W-1:0] domain;
    logic [1:0]          request_code;
    logic [1:0]          delay_slot;
    logic [VALUE_W-1:0]  delay_value;
  } cmd_t;

  // Per-domain outcome of a transaction, after the update
  typedef struct packed {
    logic    accepted;
    logic    busy;
    pstate_t state;
  } dom_status_t;

  function automatic pstate_t code_to_state(input logic [1:0] code);
    pstate_t st;
    unique case (code)
      CODE_CG:    st = PS_CG;
      CODE_ON:    st = PS_ON;
      CODE_OFF_A: st = PS_OFF;
      CODE_OFF_B: st = PS_OFF;
      default:    st = PS_OFF;
    endcase
    return st;
  endfunction

  function automatic logic [1:0] request_slot(input pstate_t tgt, input pstate_t cur);
    logic [1:0] slot;
    if (tgt == PS_OFF) begin
      slot = SLOT_ON_OFF;
    end else if (tgt == PS_CG) begin
      slot = SLOT_ON_CG;
    end else if (cur == PS_OFF) begin
      slot = SLOT_OFF_ON;
    end else begin
      slot = SLOT_CG_ON;
    end
    return slot;
  endfunction

endpackage

`default_nettype wire

// File: design/pdtc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface pdtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  domain;
  logic [1:0]  request_code;
  logic [1:0]  delay_slot;
  logic [31:0] delay_value;

  modport source (
    output valid, op, domain, request_code, delay_slot, delay_value,
    input  ready
  );
  modport sink (
    input  valid, op, domain, request_code, delay_slot, delay_value,
    output ready
  );
endinterface

// Result channel
interface pdtc_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [3:0] busy_mask;
  logic [1:0] state_host;
  logic [1:0] state_sensor_a;
  logic [1:0] state_sensor_b;
  logic [1:0] state_sensor_c;

  modport source (
    output valid, accepted, busy_mask, state_host, state_sensor_a,
           state_sensor_b, state_sensor_c,
    input  ready
  );
  modport sink (
    input  valid, accepted, busy_mask, state_host, state_sensor_a,
           state_sensor_b, state_sensor_c,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pdtc_domain.sv
`timescale 1ns / 1ps
`default_nettype none

module pdtc_domain #(
  parameter int DOMAIN_INDEX = 0,
  parameter int DELAY_WIDTH  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire pdtc_pkg::cmd_t      cmd,
  output pdtc_pkg::dom_status_t    status
);

  pdtc_pkg::pstate_t       pstate, pstate_next;
  pdtc_pkg::pstate_t       target, target_next;
  logic                    pending, pending_next;
  logic [DELAY_WIDTH-1:0]  remaining, remaining_next;
  logic [DELAY_WIDTH-1:0]  delay_word [4];

  logic              hit;
  logic              req_ok;
  logic              wr_ok;
  logic              tick;
  pdtc_pkg::pstate_t req_state;
  logic [1:0]        req_slot;

  // Decode the transaction for this domain
  assign hit       = fire && (32'(cmd.domain) == DOMAIN_INDEX);
  assign req_ok    = hit && (cmd.op == pdtc_pkg::OP_REQUEST) && !pending;
  assign wr_ok     = hit && (cmd.op == pdtc_pkg::OP_WRITE);
  assign tick      = fire && (cmd.op == pdtc_pkg::OP_TICK);
  assign req_state = pdtc_pkg::code_to_state(cmd.request_code);
  assign req_slot  = pdtc_pkg::request_slot(req_state, pstate);

  // Advance countdown on tick and switch to the target state when it runs out; load it on an accepted request
  always_comb begin
    pstate_next    = pstate;
    target_next    = target;
    pending_next   = pending;
    remaining_next = remaining;
    if (tick && pending) begin
      if (remaining[DELAY_WIDTH-1:1] == '0) begin
        pstate_next    = target;
        pending_next   = 1'b0;
        remaining_next = '0;
      end else begin
        remaining_next = remaining - DELAY_WIDTH'(1);
      end
    end
    if (req_ok) begin
      target_next    = req_state;
      remaining_next = delay_word[req_slot];
      pending_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= pdtc_pkg::PS_OFF;
      target    <= pdtc_pkg::PS_OFF;
      pending   <= 1'b0;
      remaining <= '0;
    end else begin
      pstate    <= pstate_next;
      target    <= target_next;
      pending   <= pending_next;
      remaining <= remaining_next;
    end
  end

  // Delay table words of this domain, one per slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        delay_word[i] <= DELAY_WIDTH'(1);
      end
    end else if (wr_ok) begin
      delay_word[cmd.delay_slot] <= DELAY_WIDTH'(cmd.delay_value);
    end
  end

  assign status.accepted = req_ok || wr_ok;
  assign status.busy     = pending_next;
  assign status.state    = pstate_next;

endmodule

`default_nettype wire

// File: design/power_domain_transition_controller_top.sv
// Power domain transition controller.
// An accepted item's result is loaded into the output register in the next cycle.
// Throughput: one item per cycle; every domain updates in parallel in one pass.
// The item side stalls only while the output register holds an untaken result.
// Reset (rst, synchronous): all domains off, nothing pending, delays all one.
`timescale 1ns / 1ps
`default_nettype none

module power_domain_transition_controller_top #(
  parameter int NUM_DOMAINS = 4,
  parameter int DELAY_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  pdtc_in_if.sink    item,
  pdtc_out_if.source result
);

  localparam int SHOWN = (NUM_DOMAINS < pdtc_pkg::REPORTED_DOMAINS) ?
                         NUM_DOMAINS : pdtc_pkg::REPORTED_DOMAINS;

  logic                  fire;
  pdtc_pkg::cmd_t        cmd;
  pdtc_pkg::dom_status_t status [NUM_DOMAINS];
  logic [NUM_DOMAINS-1:0] acc_vec;
  logic [3:0]            busy_vec;
  logic [1:0]            state_vec [4];

  logic       out_valid;
  logic       out_accepted;
  logic [3:0] out_busy;
  logic [1:0] out_state [4];

  // Take a transaction whenever the result register is free or draining
  assign item.ready = !out_valid || result.ready;
  assign fire       = item.valid && item.ready;

  assign cmd.op           = pdtc_pkg::op_t'(item.op);
  assign cmd.domain       = item.domain;
  assign cmd.request_code = item.request_code;
  assign cmd.delay_slot   = item.delay_slot;
  assign cmd.delay_value  = item.delay_value;

  // One controller per domain
  for (genvar d = 0; d < NUM_DOMAINS; d++) begin : g_dom
    pdtc_domain #(
      .DOMAIN_INDEX (d),
      .DELAY_WIDTH  (DELAY_WIDTH)
    ) u_dom (
      .clk    (clk),
      .rst    (rst),
      .fire   (fire),
      .cmd    (cmd),
      .status (status[d])
    );
    assign acc_vec[d] = status[d].accepted;
  end

  // Gather the reported domains; missing ones read as off and idle
  for (genvar r = 0; r < 4; r++) begin : g_rep
    if (r < SHOWN) begin : g_on
      assign busy_vec[r]  = status[r].busy;
      assign state_vec[r] = status[r].state;
    end else begin : g_off
      assign busy_vec[r]  = 1'b0;
      assign state_vec[r] = pdtc_pkg::PS_OFF;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted <= |acc_vec;
      out_busy     <= busy_vec;
      for (int i = 0; i < 4; i++) begin
        out_state[i] <= state_vec[i];
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.accepted       = out_accepted;
  assign result.busy_mask      = out_busy;
  assign result.state_host     = out_state[0];
  assign result.state_sensor_a = out_state[1];
  assign result.state_sensor_b = out_state[2];
  assign result.state_sensor_c = out_state[3];

endmodule

`default_nettype wire
